// File: hw/rtl/jse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, constants and the escape table for the JavaScript string
// escaper with UTF-8 decoding.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam int RUN_MAX = 6;
	localparam int CNT_W   = 3;

	typedef logic [7:0] byte_t;

	// Output bytes caused by one input byte, in order from index zero.
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} run_t;

	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	localparam logic [15:0] VAL_LSEP = 16'h2028;
	localparam logic [15:0] VAL_PSEP = 16'h2029;

	// Length of the unit that a byte opens.
	function automatic logic [1:0] unit_len(input byte_t b);
		logic [1:0] len;
		len = LEN_ONE;
		if (b[7:5] == 3'b110) begin
			len = LEN_TWO;
		end else if (b[7:4] == 4'b1110) begin
			len = LEN_THREE;
		end
		return len;
	endfunction

	// Escaped form of one decoded unit; above 0xFF only separators yield bytes.
	// Raw holds the source bytes, passed unchanged for a value up to 0xFF with no entry.
	function automatic run_t emit_unit(input logic [15:0] value,
			input logic [2:0][7:0] raw, input logic [1:0] n);
		run_t r;
		r = '0;
		if (value[15:8] != 8'h00) begin
			if (value == VAL_LSEP || value == VAL_PSEP) begin
				r.bytes[0] = "\\";
				r.bytes[1] = "u";
				r.bytes[2] = "2";
				r.bytes[3] = "0";
				r.bytes[4] = "2";
				r.bytes[5] = value[0] ? "9" : "8";
				r.cnt      = 3'd6;
			end
		end else begin
			unique case (value[7:0]) inside
				8'h00, 8'h22, 8'h27, 8'h26, 8'h3C, 8'h3E, 8'h3D, 8'h0B: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "x";
					r.bytes[2] = {4'h3, value[7:4]};
					r.bytes[3] = (value[3:0] < 4'hA) ? {4'h3, value[3:0]}
						: (8'h57 + {4'h0, value[3:0]});
					r.cnt      = 3'd4;
				end
				8'h5C: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "\\";
					r.cnt      = 3'd2;
				end
				8'h09: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "t";
					r.cnt      = 3'd2;
				end
				8'h0D: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "r";
					r.cnt      = 3'd2;
				end
				8'h0A: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "n";
					r.cnt      = 3'd2;
				end
				8'h08: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "b";
					r.cnt      = 3'd2;
				end
				8'h0C: begin
					r.bytes[0] = "\\";
					r.bytes[1] = "f";
					r.cnt      = 3'd2;
				end
				default: begin
					r.bytes[0] = raw[0];
					r.bytes[1] = raw[1];
					r.bytes[2] = raw[2];
					r.cnt      = {1'b0, n};
				end
			endcase
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/jse_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_in_if
// Request channel carrying one string byte and its end-of-string mark.
// ----------------------------------------------------------------------------
interface jse_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  in_byte;
	logic        is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// File: hw/rtl/jse_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_out_if
// Request channel carrying one escaped output byte and its markers.
// ----------------------------------------------------------------------------
interface jse_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_end;
	logic        string_end;

	modport source (output valid, output out_byte, output byte_valid,
		output run_end, output string_end, input ready);
	modport sink   (input valid, input out_byte, input byte_valid,
		input run_end, input string_end, output ready);
endinterface

// File: hw/rtl/jse_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_dec
// UTF-8 unit tracker: holds a pending lead and tail byte and forms the
// escaped bytes that one input byte causes.
// ----------------------------------------------------------------------------
module jse_dec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  jse_pkg::byte_t   in_byte,
	input  logic             is_last,
	output jse_pkg::run_t    run,
	output logic             pending
);

	logic [1:0]      exp_q, exp_d;
	logic [1:0]      held_q, held_d;
	jse_pkg::byte_t  held0_q, held0_d;
	jse_pkg::byte_t  held1_q, held1_d;

	logic            is_tail;
	logic [1:0]      len;
	logic            pre;
	logic            suf;
	logic [15:0]     value;
	logic [2:0][7:0] raw;
	jse_pkg::run_t   unit_r;

	assign is_tail = (in_byte[7:6] == 2'b10);
	assign len     = jse_pkg::unit_len(in_byte);
	assign pending = (exp_q != 2'd0);

	always_comb begin
		exp_d   = exp_q;
		held_d  = held_q;
		held0_d = held0_q;
		held1_d = held1_q;
		pre     = 1'b0;
		suf     = 1'b0;
		value   = '0;
		raw     = '0;
		unit_r  = '0;
		if (!pending || !is_tail) begin
			// A byte that is not a tail drops any pending lead; a held tail passes raw.
			pre    = pending && (held_q == 2'd2);
			exp_d  = 2'd0;
			held_d = 2'd0;
			if (len == jse_pkg::LEN_ONE) begin
				raw[0] = in_byte;
				unit_r = jse_pkg::emit_unit({8'h00, in_byte}, raw, jse_pkg::LEN_ONE);
			end else begin
				exp_d   = len;
				held_d  = 2'd1;
				held0_d = in_byte;
			end
		end else if (held_q == 2'd1 && exp_q == jse_pkg::LEN_THREE) begin
			held1_d = in_byte;
			held_d  = 2'd2;
		end else begin
			if (exp_q == jse_pkg::LEN_TWO) begin
				value = {5'b0, held0_q[4:0], in_byte[5:0]};
			end else begin
				value = {held0_q[3:0], held1_q[5:0], in_byte[5:0]};
			end
			raw[0] = held0_q;
			raw[1] = (held_q == 2'd2) ? held1_q : in_byte;
			raw[2] = in_byte;
			unit_r = jse_pkg::emit_unit(value, raw, held_q + 2'd1);
			exp_d  = 2'd0;
			held_d = 2'd0;
		end
		// At the end of the string a pending unit is abandoned as well.
		if (is_last) begin
			suf    = (held_d == 2'd2);
			exp_d  = 2'd0;
			held_d = 2'd0;
		end
	end

	always_comb begin
		run = unit_r;
		if (suf) begin
			run          = '0;
			run.bytes[0] = in_byte;
			run.cnt      = 3'd1;
		end else if (pre) begin
			run.bytes = {unit_r.bytes[jse_pkg::RUN_MAX-2:0], held1_q};
			run.cnt   = unit_r.cnt + 3'd1;
		end
		run.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= 2'd0;
			held_q <= 2'd0;
		end else if (adv) begin
			exp_q  <= exp_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
		end
	end

endmodule

// File: hw/rtl/jse_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_ser
// Result register that hands out the bytes of one run, one per request.
// ----------------------------------------------------------------------------
module jse_ser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  jse_pkg::run_t run,
	output logic          free,
	jse_out_if.source     escaped
);

	logic [jse_pkg::RUN_MAX-1:0][7:0] bytes_s2;
	logic [jse_pkg::CNT_W-1:0]        rem_s2;
	logic                             last_s2;
	logic                             bv_s2;
	logic                             take;

	assign take = (rem_s2 != '0) && escaped.ready;
	assign free = (rem_s2 == '0) || ((rem_s2 == 3'd1) && escaped.ready);

	assign escaped.valid      = (rem_s2 != '0);
	assign escaped.out_byte   = bytes_s2[0];
	assign escaped.byte_valid = bv_s2;
	assign escaped.run_end    = (rem_s2 == 3'd1);
	assign escaped.string_end = (rem_s2 == 3'd1) && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= '0;
		end else if (load) begin
			// An input that yields nothing still gives one empty marker at string end.
			if (run.cnt != '0) begin
				rem_s2 <= run.cnt;
			end else begin
				rem_s2 <= {2'b00, run.last};
			end
		end else if (take) begin
			rem_s2 <= rem_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= run.bytes;
			last_s2  <= run.last;
			bv_s2    <= (run.cnt != '0);
		end else if (take) begin
			bytes_s2 <= {8'h00, bytes_s2[jse_pkg::RUN_MAX-1:1]};
		end
	end

endmodule

// File: hw/rtl/utf8_javascript_string_escaper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_javascript_string_escaper_top
// Streaming JavaScript string escaper with UTF-8 decoding.
// ----------------------------------------------------------------------------
// Usage:
// The text channel takes one string byte per request, with is_last set on
// the final byte. The escaped channel returns the escaped bytes; run_end marks
// the last byte caused by one input byte and string_end the last byte of the
// string. A string whose final byte yields nothing ends with one marker that
// has byte_valid low and out_byte zero.
// A byte's first result passes the input register, then the result register.
// Throughput: one input byte per cycle while each yields at most one result
// and the receiver is ready. A byte that yields more results holds the result
// register until all are taken, which sets the rate; the input register fills
// and ready drops meanwhile.
// Reset clears the pending UTF-8 unit and both registers; no clearing pass.
// When the receiver stalls, the current result holds and the input stalls
// once the input register is full.
// ----------------------------------------------------------------------------
module utf8_javascript_string_escaper_top (
	input  logic      clk,
	input  logic      arst_n,
	jse_in_if.sink    text,
	jse_out_if.source escaped
);

	jse_pkg::byte_t in_byte_s1;
	logic           is_last_s1;
	logic           valid_s1;
	logic           free;
	logic           adv;
	logic           pending;
	jse_pkg::run_t  run;

	assign adv        = valid_s1 && free;
	assign text.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			in_byte_s1 <= text.in_byte;
			is_last_s1 <= text.is_last;
		end
	end

	jse_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_byte (in_byte_s1),
		.is_last (is_last_s1),
		.run     (run),
		.pending (pending)
	);

	jse_ser u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (adv),
		.run     (run),
		.free    (free),
		.escaped (escaped)
	);

	a_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		escaped.valid && !escaped.byte_valid |-> escaped.run_end && escaped.string_end)
		else $error("empty marker without end flags");

	a_string_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		escaped.valid && escaped.string_end |-> escaped.run_end)
		else $error("string end inside a run");

	a_no_pending_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_last_s1 |=> !pending)
		else $error("unit still pending after string end");

	a_idle_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!escaped.valid |-> text.ready)
		else $error("input blocked while result register empty");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 JavaScript string escaper. Strings of
// single bytes, well-formed and broken UTF-8 units and truncated tails are
// streamed in. A byte-level escaper model predicts the escaped stream, which
// is compared field by field with every accepted output request. Both sides
// idle and stall at random, in phases.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS = 260;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int REPORT_MAX   = 10;

	localparam jse_pkg::byte_t ESCAPABLE [14] = '{8'h00, 8'h22, 8'h27, 8'h26, 8'h3C,
		8'h3E, 8'h3D, 8'h0B, 8'h5C, 8'h09, 8'h0D, 8'h0A, 8'h08, 8'h0C};

	typedef enum int {
		UNIT_TABLE_CHAR,
		UNIT_ASCII,
		UNIT_TWO_BYTE,
		UNIT_THREE_BYTE,
		UNIT_BROKEN,
		UNIT_NOISE
	} unit_kind_t;

	typedef struct packed {
		jse_pkg::byte_t ch;
		logic           fin;
	} text_req_t;

	typedef struct packed {
		jse_pkg::byte_t out_byte;
		logic           byte_valid;
		logic           run_end;
		logic           string_end;
	} escaped_res_t;

	logic clk = 1'b0;
	logic arst_n;

	jse_in_if  text_ch ();
	jse_out_if esc_ch ();

	utf8_javascript_string_escaper_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.escaped (esc_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	text_req_t    pending_text [$];
	escaped_res_t escaped_due [$];
	int           text_total;
	int           fail_cnt;
	int           quiet_cycles;
	logic         text_seen;

	// Model state: the open UTF-8 unit and the bytes one input byte yields.
	logic [1:0]     unit_len_pend;
	logic [1:0]     held_n;
	jse_pkg::byte_t held_b [2];
	jse_pkg::byte_t run_buf [jse_pkg::RUN_MAX];
	int             run_n;

	function automatic void put_out(input jse_pkg::byte_t c);
		if (run_n < jse_pkg::RUN_MAX) begin
			run_buf[run_n] = c;
			run_n++;
		end
	endfunction

	function automatic void put_hex(input jse_pkg::byte_t hi, input jse_pkg::byte_t lo);
		put_out("\\");
		put_out("x");
		put_out(hi);
		put_out(lo);
	endfunction

	function automatic void put_pair(input jse_pkg::byte_t c);
		put_out("\\");
		put_out(c);
	endfunction

	function automatic void escape_value(input logic [15:0] v, input logic [2:0][7:0] raw,
			input int n);
		if (v[15:8] != 8'h00) begin
			// Only the line and paragraph separators survive above 0xFF.
			if (v == 16'h2028 || v == 16'h2029) begin
				put_out("\\");
				put_out("u");
				put_out("2");
				put_out("0");
				put_out("2");
				put_out(v[0] ? "9" : "8");
			end
			return;
		end
		case (v[7:0])
			8'h00: put_hex("0", "0");
			8'h22: put_hex("2", "2");
			8'h27: put_hex("2", "7");
			8'h26: put_hex("2", "6");
			8'h3C: put_hex("3", "c");
			8'h3E: put_hex("3", "e");
			8'h3D: put_hex("3", "d");
			8'h0B: put_hex("0", "b");
			8'h5C: put_pair("\\");
			8'h09: put_pair("t");
			8'h0D: put_pair("r");
			8'h0A: put_pair("n");
			8'h08: put_pair("b");
			8'h0C: put_pair("f");
			default: begin
				for (int i = 0; i < n; i++) begin
					put_out(raw[i]);
				end
			end
		endcase
	endfunction

	function automatic void open_unit(input jse_pkg::byte_t b);
		logic [2:0][7:0] raw;
		raw = '0;
		if (b >= 8'hC0 && b <= 8'hDF) begin
			held_b[0] = b;
			held_n = 2'd1;
			unit_len_pend = 2'd2;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			held_b[0] = b;
			held_n = 2'd1;
			unit_len_pend = 2'd3;
		end else begin
			raw[0] = b;
			escape_value({8'h00, b}, raw, 1);
		end
	endfunction

	// The lead byte is lost; a held tail byte passes on its own.
	function automatic void drop_unit();
		logic [2:0][7:0] raw;
		raw = '0;
		if (held_n == 2'd2) begin
			raw[0] = held_b[1];
			escape_value({8'h00, held_b[1]}, raw, 1);
		end
		unit_len_pend = 2'd0;
		held_n = 2'd0;
	endfunction

	function automatic void decode_byte(input jse_pkg::byte_t b);
		logic [15:0]     v;
		logic [2:0][7:0] raw;
		int              n;
		raw = '0;
		if (unit_len_pend == 2'd0 || held_n == 2'd0 || held_n > 2'd2) begin
			unit_len_pend = 2'd0;
			held_n = 2'd0;
			open_unit(b);
			return;
		end
		if (b[7:6] != 2'b10) begin
			drop_unit();
			open_unit(b);
			return;
		end
		if (held_n + 1 < unit_len_pend) begin
			held_b[held_n[0]] = b;
			held_n++;
			return;
		end
		v = {8'h00, held_b[0] & (8'hFF >> unit_len_pend)};
		raw[0] = held_b[0];
		for (int i = 1; i < held_n; i++) begin
			raw[i] = held_b[i & 1];
			v = (v << 6) | {10'd0, held_b[i & 1][5:0]};
		end
		raw[held_n] = b;
		v = (v << 6) | {10'd0, b[5:0]};
		n = held_n + 1;
		unit_len_pend = 2'd0;
		held_n = 2'd0;
		escape_value(v, raw, n);
	endfunction

	function automatic void predict_escape(input text_req_t r);
		escaped_res_t e;
		run_n = 0;
		decode_byte(r.ch);
		if (r.fin && unit_len_pend != 2'd0) begin
			drop_unit();
		end
		if (run_n == 0) begin
			if (r.fin) begin
				e = '{out_byte: 8'h00, byte_valid: 1'b0, run_end: 1'b1, string_end: 1'b1};
				escaped_due.push_back(e);
			end
		end else begin
			for (int k = 0; k < run_n; k++) begin
				e.out_byte   = run_buf[k];
				e.byte_valid = 1'b1;
				e.run_end    = (k == run_n - 1);
				e.string_end = (k == run_n - 1) && r.fin;
				escaped_due.push_back(e);
			end
		end
	endfunction

	function automatic void add_text(input jse_pkg::byte_t ch, input logic fin);
		text_req_t r;
		r.ch  = ch;
		r.fin = fin;
		pending_text.push_back(r);
	endfunction

	function automatic unit_kind_t pick_kind();
		int p;
		unit_kind_t k;
		p = $urandom_range(0, 99);
		if (p < 25) begin
			k = UNIT_TABLE_CHAR;
		end else if (p < 42) begin
			k = UNIT_ASCII;
		end else if (p < 58) begin
			k = UNIT_TWO_BYTE;
		end else if (p < 74) begin
			k = UNIT_THREE_BYTE;
		end else if (p < 86) begin
			k = UNIT_BROKEN;
		end else begin
			k = UNIT_NOISE;
		end
		return k;
	endfunction

	function automatic jse_pkg::byte_t any_tail();
		return jse_pkg::byte_t'($urandom_range(8'h80, 8'hBF));
	endfunction

	function automatic void add_random_string();
		jse_pkg::byte_t s [$];
		jse_pkg::byte_t t;
		int             units;
		units = $urandom_range(1, 10);
		for (int u = 0; u < units; u++) begin
			t = ESCAPABLE[$urandom_range(0, 13)];
			case (pick_kind())
				UNIT_TABLE_CHAR: s.push_back(t);
				UNIT_ASCII: s.push_back(jse_pkg::byte_t'($urandom_range(8'h20, 8'h7E)));
				UNIT_TWO_BYTE: begin
					// A third of these are overlong forms of escapable characters.
					if ($urandom_range(0, 2) == 0) begin
						s.push_back({6'b110000, t[7:6]});
						s.push_back({2'b10, t[5:0]});
					end else begin
						s.push_back(jse_pkg::byte_t'($urandom_range(8'hC0, 8'hDF)));
						s.push_back(any_tail());
					end
				end
				UNIT_THREE_BYTE: begin
					case ($urandom_range(0, 3))
						0: begin
							s.push_back(8'hE2);
							s.push_back(8'h80);
							s.push_back($urandom_range(0, 1) ? 8'hA9 : 8'hA8);
						end
						1: begin
							s.push_back(8'hE0);
							s.push_back({6'b100000, t[7:6]});
							s.push_back({2'b10, t[5:0]});
						end
						default: begin
							s.push_back(jse_pkg::byte_t'($urandom_range(8'hE0, 8'hEF)));
							s.push_back(any_tail());
							s.push_back(any_tail());
						end
					endcase
				end
				UNIT_BROKEN: begin
					s.push_back(jse_pkg::byte_t'($urandom_range(8'hC0, 8'hEF)));
					if ($urandom_range(0, 1)) begin
						s.push_back(any_tail());
					end
					if ($urandom_range(0, 1)) begin
						s.push_back(jse_pkg::byte_t'($urandom_range(8'h00, 8'h7F)));
					end else begin
						s.push_back(jse_pkg::byte_t'($urandom_range(8'hC0, 8'hFF)));
					end
				end
				default: s.push_back(jse_pkg::byte_t'($urandom_range(0, 255)));
			endcase
		end
		// Some strings stop in the middle of a unit.
		if ($urandom_range(0, 4) == 0) begin
			s.push_back(jse_pkg::byte_t'($urandom_range(8'hC0, 8'hEF)));
			if ($urandom_range(0, 1)) begin
				s.push_back(any_tail());
			end
		end
		for (int i = 0; i < s.size(); i++) begin
			add_text(s[i], i == s.size() - 1);
		end
	endfunction

	function automatic int idle_mode();
		return ((text_total - pending_text.size()) * 4) / text_total;
	endfunction

	// Driver: a new request goes out at the falling edge after the last one was taken.
	always @(negedge clk) begin
		int send_gap;
		int recv_gap;
		text_req_t r;
		if (arst_n) begin
			case (idle_mode())
				0:       begin send_gap = 0;  recv_gap = 0;  end
				1:       begin send_gap = 65; recv_gap = 0;  end
				2:       begin send_gap = 0;  recv_gap = 65; end
				default: begin send_gap = 7;  recv_gap = 7;  end
			endcase
			if (!text_ch.valid || text_seen) begin
				if (pending_text.size() != 0 && $urandom_range(0, 99) >= send_gap) begin
					r = pending_text.pop_front();
					text_ch.in_byte <= r.ch;
					text_ch.is_last <= r.fin;
					text_ch.valid   <= 1'b1;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
			esc_ch.ready <= ($urandom_range(0, 99) >= recv_gap);
		end
	end

	// Monitor: both channels are sampled at the rising edge.
	always @(posedge clk) begin
		escaped_res_t got;
		escaped_res_t want;
		logic         out_seen;
		if (arst_n) begin
			text_seen = text_ch.valid && text_ch.ready;
			out_seen  = esc_ch.valid && esc_ch.ready;
			if (text_seen) begin
				predict_escape('{ch: text_ch.in_byte, fin: text_ch.is_last});
			end
			if (out_seen) begin
				got = '{out_byte: esc_ch.out_byte, byte_valid: esc_ch.byte_valid,
					run_end: esc_ch.run_end, string_end: esc_ch.string_end};
				if (escaped_due.size() == 0) begin
					if (fail_cnt < REPORT_MAX) begin
						$display({"unexpected escaped byte %02h valid %b",
							" run_end %b string_end %b"},
							got.out_byte, got.byte_valid, got.run_end, got.string_end);
					end
					fail_cnt++;
				end else begin
					want = escaped_due.pop_front();
					if (got !== want) begin
						if (fail_cnt < REPORT_MAX) begin
							$display({"mismatch at %0t: expected byte %02h valid %b",
								" run_end %b string_end %b, got byte %02h valid %b",
								" run_end %b string_end %b"},
								$realtime, want.out_byte, want.byte_valid, want.run_end,
								want.string_end, got.out_byte, got.byte_valid, got.run_end,
								got.string_end);
						end
						fail_cnt++;
					end
				end
			end
			if (text_seen || out_seen) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		text_ch.valid   = 1'b0;
		text_ch.in_byte = 8'h00;
		text_ch.is_last = 1'b0;
		esc_ch.ready    = 1'b0;
		text_seen       = 1'b0;
		fail_cnt        = 0;
		quiet_cycles    = 0;
		unit_len_pend   = 2'd0;
		held_n          = 2'd0;
		held_b[0]       = 8'h00;
		held_b[1]       = 8'h00;
		run_n           = 0;

		// Every table entry, then the extreme raw byte closing the string.
		foreach (ESCAPABLE[i]) begin
			add_text(ESCAPABLE[i], 1'b0);
		end
		add_text(8'hFF, 1'b1);
		// Both separators, an overlong quote, a bad tail after a lead alone and
		// after a lead with one tail, and a string ending inside a unit.
		add_text(8'hE2, 1'b0); add_text(8'h80, 1'b0); add_text(8'hA8, 1'b0);
		add_text(8'hE2, 1'b0); add_text(8'h80, 1'b0); add_text(8'hA9, 1'b0);
		add_text(8'hC0, 1'b0); add_text(8'hA2, 1'b0);
		add_text(8'hC3, 1'b0); add_text(8'h22, 1'b0);
		add_text(8'hE2, 1'b0); add_text(8'h80, 1'b0); add_text(8'h3C, 1'b0);
		add_text(8'hE2, 1'b0); add_text(8'hB0, 1'b1);
		// A string that is only a lead byte yields just the empty end marker.
		add_text(8'hC3, 1'b1);

		while (pending_text.size() < RANDOM_ITEMS) begin
			add_random_string();
		end
		text_total = pending_text.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_text.size() == 0 && !text_ch.valid && escaped_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && escaped_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/jse_pkg.sv
hw/rtl/jse_in_if.sv
hw/rtl/jse_out_if.sv
hw/rtl/jse_dec.sv
hw/rtl/jse_ser.sv
hw/rtl/utf8_javascript_string_escaper_top.sv
bench/tb_top.sv
